[sv/quad_rotor_speed_mixer_defines.svh]
// quad_rotor_speed_mixer_defines.svh: assertion macros for the rotor speed mixer.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef QUAD_ROTOR_SPEED_MIXER_DEFINES_SVH
`define QUAD_ROTOR_SPEED_MIXER_DEFINES_SVH

`ifndef SYNTHESIS
// Check an expression at every clock edge outside reset.
`define QRSM_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("qrsm: assertion failed");
// Check a consequence in the cycle after the antecedent holds.
`define QRSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrsm: next-cycle assertion failed");
`else
`define QRSM_ASSERT(lbl, expr)
`define QRSM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/qrsm_pkg.sv]
// qrsm_pkg: widths, sign rows, register codes and shared types of the rotor mixer.
// No dependencies; imported by every module of the block.
`default_nettype none

package qrsm_pkg;

  localparam int NUM_ROTORS  = 4;
  localparam int IN_W        = 32;
  localparam int COEF_W      = 32;
  localparam int PROD_W      = 64;   // signed Q8.24 x unsigned Q24.8
  localparam int PAIR_W      = PROD_W + 1;
  localparam int SUM_W       = PROD_W + 2;
  localparam int FRAC_DROP   = 16;
  localparam int Q_W         = SUM_W - FRAC_DROP;
  localparam int SPD_W       = 21;
  localparam int RAD_W       = 2 * SPD_W;
  localparam int SQRT_STAGES = SPD_W;
  localparam int MAXSPD_W    = 13;
  localparam int LIM1_W      = MAXSPD_W + 9;
  localparam int LIMSQ_W     = 2 * LIM1_W;
  localparam int PIPE_DEPTH  = 3 + SQRT_STAGES;
  localparam int MASK_LSB    = NUM_ROTORS * SPD_W;
  localparam int OUT_W       = MASK_LSB + NUM_ROTORS;
  localparam int IN_DATA_W   = 4 * IN_W;
  localparam int ADDR_W      = 5;
  localparam int PDATA_W     = 32;

  localparam logic [MAXSPD_W-1:0] MAX_SPEED_RESET = 13'd6104;

  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_THRUST_CF = 3'd1,
    REG_ARM_CF    = 3'd2,
    REG_YAW_CF    = 3'd3,
    REG_MAX_SPEED = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic roll_neg;
    logic pitch_neg;
    logic yaw_neg;
  } sign_row_t;

  localparam sign_row_t SIGN_ROWS [NUM_ROTORS] = '{
    '{roll_neg: 1'b1, pitch_neg: 1'b1, yaw_neg: 1'b1},
    '{roll_neg: 1'b1, pitch_neg: 1'b0, yaw_neg: 1'b0},
    '{roll_neg: 1'b0, pitch_neg: 1'b0, yaw_neg: 1'b1},
    '{roll_neg: 1'b0, pitch_neg: 1'b1, yaw_neg: 1'b0}
  };

  typedef struct packed {
    logic signed [PROD_W-1:0] thrust;
    logic signed [PROD_W-1:0] roll;
    logic signed [PROD_W-1:0] pitch;
    logic signed [PROD_W-1:0] yaw;
  } prod_set_t;

  typedef struct packed {
    logic               adv;
    logic               en;
    logic [LIMSQ_W-1:0] lim_sq;
  } lane_ctrl_t;

endpackage

`default_nettype wire

[sv/qrsm_prod.sv]
// qrsm_prod: the four input-times-coefficient products shared by all lanes.
// Depends on qrsm_pkg.
`default_nettype none

module qrsm_prod import qrsm_pkg::*; (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [IN_W-1:0]  thrust,
  input  logic signed [IN_W-1:0]  roll_torque,
  input  logic signed [IN_W-1:0]  pitch_torque,
  input  logic signed [IN_W-1:0]  yaw_torque,
  input  logic [COEF_W-1:0]       thrust_coeff,
  input  logic [COEF_W-1:0]       arm_coeff,
  input  logic [COEF_W-1:0]       yaw_coeff,
  output prod_set_t               prods
);

  logic signed [PROD_W:0] m_thrust;
  logic signed [PROD_W:0] m_roll;
  logic signed [PROD_W:0] m_pitch;
  logic signed [PROD_W:0] m_yaw;
  prod_set_t              prods_r;

  // coefficients are unsigned: extend with a zero sign bit
  assign m_thrust = PAIR_W'(thrust)       * PAIR_W'($signed({1'b0, thrust_coeff}));
  assign m_roll   = PAIR_W'(roll_torque)  * PAIR_W'($signed({1'b0, arm_coeff}));
  assign m_pitch  = PAIR_W'(pitch_torque) * PAIR_W'($signed({1'b0, arm_coeff}));
  assign m_yaw    = PAIR_W'(yaw_torque)   * PAIR_W'($signed({1'b0, yaw_coeff}));

  always_ff @(posedge clk) begin
    if (adv) begin
      prods_r.thrust <= m_thrust[PROD_W-1:0];
      prods_r.roll   <= m_roll[PROD_W-1:0];
      prods_r.pitch  <= m_pitch[PROD_W-1:0];
      prods_r.yaw    <= m_yaw[PROD_W-1:0];
    end
  end

  assign prods = prods_r;

endmodule

`default_nettype wire

[sv/qrsm_sqrt.sv]
// qrsm_sqrt: pipelined integer square root, one result bit per stage.
// Depends on qrsm_pkg.
`default_nettype none

module qrsm_sqrt import qrsm_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [RAD_W-1:0] rad,
  input  logic             clip_in,
  output logic [SPD_W-1:0] root,
  output logic             clip_out
);

  logic [RAD_W-1:0] x_r    [SQRT_STAGES];
  logic [RAD_W-1:0] r_r    [SQRT_STAGES];
  logic             clip_r [SQRT_STAGES];
  logic [RAD_W-1:0] x_in   [SQRT_STAGES];
  logic [RAD_W-1:0] r_in   [SQRT_STAGES];
  logic             c_in   [SQRT_STAGES];
  logic [RAD_W-1:0] x_nxt  [SQRT_STAGES];
  logic [RAD_W-1:0] r_nxt  [SQRT_STAGES];

  always_comb begin
    x_in[0] = rad;
    r_in[0] = '0;
    c_in[0] = clip_in;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      x_in[k] = x_r[k-1];
      r_in[k] = r_r[k-1];
      c_in[k] = clip_r[k-1];
    end
  end

  // stage k tries the root bit of weight 2^(SQRT_STAGES-1-k); bitv is its square, 4^(SQRT_STAGES-1-k)
  always_comb begin
    logic [RAD_W-1:0] bitv;
    logic [RAD_W-1:0] trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      bitv  = RAD_W'(1) << (2 * (SQRT_STAGES - 1 - k));
      trial = r_in[k] + bitv;
      if (x_in[k] >= trial) begin
        x_nxt[k] = x_in[k] - trial;
        r_nxt[k] = (r_in[k] >> 1) + bitv;
      end else begin
        x_nxt[k] = x_in[k];
        r_nxt[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        x_r[k]    <= x_nxt[k];
        r_r[k]    <= r_nxt[k];
        clip_r[k] <= c_in[k];
      end
    end
  end

  assign root     = r_r[SQRT_STAGES-1][SPD_W-1:0];
  assign clip_out = clip_r[SQRT_STAGES-1];

endmodule

`default_nettype wire

[sv/qrsm_lane.sv]
// qrsm_lane: one rotor's signed sum, clamp, limit compare and square root.
// Depends on qrsm_pkg and qrsm_sqrt.
`default_nettype none

module qrsm_lane import qrsm_pkg::*; (
  input  logic             clk,
  input  lane_ctrl_t       ctrl,
  input  sign_row_t        signs,
  input  prod_set_t        prods,
  output logic [SPD_W-1:0] root,
  output logic             clip
);

  logic signed [PAIR_W-1:0] roll_x;
  logic signed [PAIR_W-1:0] pitch_x;
  logic signed [PAIR_W-1:0] yaw_x;
  logic signed [PAIR_W-1:0] pa_r;
  logic signed [PAIR_W-1:0] pb_r;
  logic signed [SUM_W-1:0]  sum;
  logic [Q_W-1:0]           q;
  logic [RAD_W-1:0]         rad_r;
  logic                     clip_r;
  logic                     clip_nxt;

  // widen before negating so the most negative product survives
  assign roll_x  = PAIR_W'(prods.roll);
  assign pitch_x = PAIR_W'(prods.pitch);
  assign yaw_x   = PAIR_W'(prods.yaw);

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      pa_r <= PAIR_W'(prods.thrust) + (signs.roll_neg ? -roll_x : roll_x);
      pb_r <= (signs.pitch_neg ? -pitch_x : pitch_x) + (signs.yaw_neg ? -yaw_x : yaw_x);
    end
  end

  assign sum = SUM_W'(pa_r) + SUM_W'(pb_r);

  // clamp negative sums (every sum while disabled), drop 16 fraction bits, compare with the squared limit
  always_comb begin
    if (!ctrl.en || sum[SUM_W-1]) begin
      q = '0;
    end else begin
      q = sum[SUM_W-1:FRAC_DROP];
    end
    clip_nxt = (q >= Q_W'(ctrl.lim_sq));
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      rad_r  <= q[RAD_W-1:0];
      clip_r <= clip_nxt;
    end
  end

  qrsm_sqrt u_sqrt (
    .clk      (clk),
    .adv      (ctrl.adv),
    .rad      (rad_r),
    .clip_in  (clip_r),
    .root     (root),
    .clip_out (clip)
  );

endmodule

`default_nettype wire

[sv/quad_rotor_speed_mixer.sv]
// quad_rotor_speed_mixer: X-configuration quadrotor mixer, force/torque beats to rotor speeds.
// Depends on qrsm_pkg, qrsm_prod, qrsm_lane (with qrsm_sqrt) and the defines header.
//
// Usage:
//   Input stream (in_*): one beat carries thrust, roll, pitch and yaw demands,
//   signed Q8.24. Output stream (out_*): one beat per input beat, four rotor
//   speeds in unsigned Q13.8 rad/s and a clipped-rotor mask.
//   Configuration is written over the APB-style cfg_* port while the block is
//   idle: enable, three Q24.8 coefficients and the speed limit in whole rad/s.
//   From the input handshake to out_tvalid a beat passes through one product
//   stage, two sum/clamp/compare stages, 21 square root stages (one result bit
//   each, four lanes side by side) and the output register, which also merges
//   the lanes and forms the mask. One beat is taken per cycle unless the receiver stalls.
//   Reset (synchronous, active low) empties the pipeline, clears enable and
//   the coefficients and sets the limit to 6104 rad/s.
//   When the receiver stalls with a result pending, the whole pipeline holds
//   and in_tready drops; it accepts again in the cycle the result is taken.
//   While disabled every speed and the mask come out zero.
`default_nettype none
`include "quad_rotor_speed_mixer_defines.svh"

module quad_rotor_speed_mixer import qrsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // thrust [31:0], roll_torque [63:32], pitch_torque [95:64], yaw_torque [127:96]
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // rotor0_speed [20:0], rotor1_speed [41:21], rotor2_speed [62:42],
  // rotor3_speed [83:63], clipped_mask [87:84]
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [ADDR_W-1:0]    cfg_paddr,
  input  logic [PDATA_W-1:0]   cfg_pwdata,
  output logic [PDATA_W-1:0]   cfg_prdata,
  output logic                 cfg_pready
);

  // configuration registers
  logic                 enable_r;
  logic [COEF_W-1:0]    thrust_coeff_r;
  logic [COEF_W-1:0]    arm_coeff_r;
  logic [COEF_W-1:0]    yaw_coeff_r;
  logic [MAXSPD_W-1:0]  max_speed_r;
  logic [LIMSQ_W-1:0]   lim_sq_r;
  logic [LIM1_W-1:0]    lim1;
  logic [SPD_W-1:0]     lim;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  // pipeline control
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_tvalid_r;
  logic [OUT_W-1:0]      out_tdata_r;
  logic [OUT_W-1:0]      out_tdata_nxt;
  lane_ctrl_t            ctrl;
  prod_set_t             prods;
  logic [SPD_W-1:0]      root [NUM_ROTORS];
  logic                  clip [NUM_ROTORS];

  // ---------------------------------------------------------------------------
  // Configuration port: zero-wait writes, combinational read mux
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      thrust_coeff_r <= '0;
      arm_coeff_r    <= '0;
      yaw_coeff_r    <= '0;
      max_speed_r    <= MAX_SPEED_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:    enable_r       <= cfg_pwdata[0];
        REG_THRUST_CF: thrust_coeff_r <= cfg_pwdata;
        REG_ARM_CF:    arm_coeff_r    <= cfg_pwdata;
        REG_YAW_CF:    yaw_coeff_r    <= cfg_pwdata;
        REG_MAX_SPEED: max_speed_r    <= cfg_pwdata[MAXSPD_W-1:0];
        default:       ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:    cfg_prdata = PDATA_W'(enable_r);
      REG_THRUST_CF: cfg_prdata = thrust_coeff_r;
      REG_ARM_CF:    cfg_prdata = arm_coeff_r;
      REG_YAW_CF:    cfg_prdata = yaw_coeff_r;
      REG_MAX_SPEED: cfg_prdata = PDATA_W'(max_speed_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Squared limit (lim + 1)^2, refreshed every cycle from the limit register.
  assign lim  = {max_speed_r, 8'b0};
  assign lim1 = LIM1_W'(lim) + LIM1_W'(1);

  always_ff @(posedge clk) begin
    lim_sq_r <= LIMSQ_W'(lim1) * LIMSQ_W'(lim1);
  end

  // ---------------------------------------------------------------------------
  // Pipeline: advance everything together whenever the output slot frees up
  // ---------------------------------------------------------------------------
  assign adv       = ~out_tvalid_r | out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      vld_r        <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
      out_tvalid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  assign ctrl.adv    = adv;
  assign ctrl.en     = enable_r;
  assign ctrl.lim_sq = lim_sq_r;

  qrsm_prod u_prod (
    .clk          (clk),
    .adv          (adv),
    .thrust       ($signed(in_tdata[IN_W-1:0])),
    .roll_torque  ($signed(in_tdata[2*IN_W-1:IN_W])),
    .pitch_torque ($signed(in_tdata[3*IN_W-1:2*IN_W])),
    .yaw_torque   ($signed(in_tdata[4*IN_W-1:3*IN_W])),
    .thrust_coeff (thrust_coeff_r),
    .arm_coeff    (arm_coeff_r),
    .yaw_coeff    (yaw_coeff_r),
    .prods        (prods)
  );

  // One lane per rotor; each carries its own sign row.
  for (genvar g = 0; g < NUM_ROTORS; g++) begin : g_lane
    qrsm_lane u_lane (
      .clk   (clk),
      .ctrl  (ctrl),
      .signs (SIGN_ROWS[g]),
      .prods (prods),
      .root  (root[g]),
      .clip  (clip[g])
    );
  end

  // Merge: substitute the limit for clipped rotors and gather the mask.
  always_comb begin
    out_tdata_nxt = '0;
    for (int k = 0; k < NUM_ROTORS; k++) begin
      out_tdata_nxt[k*SPD_W +: SPD_W] = clip[k] ? lim : root[k];
      out_tdata_nxt[MASK_LSB + k]     = clip[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `QRSM_ASSERT(a_clip0_at_limit, !out_tvalid || !out_tdata[MASK_LSB] || (out_tdata[SPD_W-1:0] == lim))
  `QRSM_ASSERT(a_ready_when_empty, out_tvalid || in_tready)
  `QRSM_ASSERT_NEXT(a_stall_holds_pipe, !adv, $stable(vld_r) && $stable(out_tdata_r))

endmodule

`default_nettype wire

[test/quad_rotor_speed_mixer_test.sv]
// quad_rotor_speed_mixer_test: self-checking bench for the X-configuration rotor speed mixer.
// Depends on qrsm_pkg and the quad_rotor_speed_mixer RTL; predicts every result beat itself.
`timescale 1ns / 100ps

module quad_rotor_speed_mixer_test;
  import qrsm_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int PIPE_LATENCY    = 25;
  // Byte address past the last register; writes there must change nothing.
  localparam logic [ADDR_W-1:0] SPARE_ADDR = 5'd20;
  // Sign of each torque per rotor, bit i = rotor i, set means added.
  localparam logic [NUM_ROTORS-1:0] ROLL_UP  = 4'b1100;
  localparam logic [NUM_ROTORS-1:0] PITCH_UP = 4'b0110;
  localparam logic [NUM_ROTORS-1:0] YAW_UP   = 4'b1010;

  // One input beat, thrust in the lowest bits.
  typedef struct packed {
    logic [IN_W-1:0] yaw;
    logic [IN_W-1:0] pitch;
    logic [IN_W-1:0] roll;
    logic [IN_W-1:0] thrust;
  } demand_t;

  // One result beat, rotor 0 speed in the lowest bits, mask on top.
  typedef struct packed {
    logic [NUM_ROTORS-1:0]            clipped;
    logic [NUM_ROTORS-1:0][SPD_W-1:0] speed;
  } speeds_t;

  // Holds a copy of the registers, predicts rotor speeds and checks result beats in order.
  class speed_tracker;
    logic                enable;
    logic [COEF_W-1:0]   thrust_cf;
    logic [COEF_W-1:0]   arm_cf;
    logic [COEF_W-1:0]   yaw_cf;
    logic [MAXSPD_W-1:0] max_spd;
    speeds_t             pending_speeds[$];
    int                  mismatch_cnt;
    int                  speeds_checked;
    int                  clip_cnt;
    int                  clamp_cnt;

    function new();
      enable    = 1'b0;
      thrust_cf = '0;
      arm_cf    = '0;
      yaw_cf    = '0;
      max_spd   = MAX_SPEED_RESET;
    endfunction

    function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] v);
      case (idx)
        REG_ENABLE:    enable    = v[0];
        REG_THRUST_CF: thrust_cf = v;
        REG_ARM_CF:    arm_cf    = v;
        REG_YAW_CF:    yaw_cf    = v;
        REG_MAX_SPEED: max_spd   = v[MAXSPD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PDATA_W-1:0] reg_value(reg_idx_t idx);
      case (idx)
        REG_ENABLE:    return {31'd0, enable};
        REG_THRUST_CF: return thrust_cf;
        REG_ARM_CF:    return arm_cf;
        REG_YAW_CF:    return yaw_cf;
        REG_MAX_SPEED: return {19'd0, max_spd};
        default:       return '0;
      endcase
    endfunction

    // Bit-by-bit floor square root; callers keep v below 2^42.
    function logic [SPD_W-1:0] floor_root(logic [49:0] v);
      logic [49:0] r;
      logic [49:0] t;
      r = '0;
      for (int b = SPD_W - 1; b >= 0; b--) begin
        t = r | (50'd1 << b);
        if (t * t <= v) r = t;
      end
      return r[SPD_W-1:0];
    endfunction

    function speeds_t mix_rotor_speeds(demand_t d);
      speeds_t                r;
      logic signed [71:0]     thr, rol, pit, yw, acc;
      logic [49:0]            sq;
      logic [SPD_W-1:0]       lim;
      logic [SPD_W:0]         lim1;
      logic [2*SPD_W+1:0]     lim_sq;
      r = '0;
      if (!enable) return r;
      // Exact products: Q8.24 times Q24.8 leaves 32 fraction bits.
      thr = 72'($signed(d.thrust)) * $signed({40'd0, thrust_cf});
      rol = 72'($signed(d.roll))   * $signed({40'd0, arm_cf});
      pit = 72'($signed(d.pitch))  * $signed({40'd0, arm_cf});
      yw  = 72'($signed(d.yaw))    * $signed({40'd0, yaw_cf});
      lim    = {max_spd, 8'd0};
      lim1   = {1'b0, lim} + (SPD_W + 1)'(1);
      lim_sq = (2*SPD_W + 2)'(lim1) * (2*SPD_W + 2)'(lim1);
      for (int i = 0; i < NUM_ROTORS; i++) begin
        acc = thr + (ROLL_UP[i] ? rol : -rol) + (PITCH_UP[i] ? pit : -pit)
            + (YAW_UP[i] ? yw : -yw);
        // Clamp negative squared speed, then drop to 16 fraction bits.
        if (acc < 0) begin
          sq = '0;
          clamp_cnt++;
        end else begin
          sq = acc[65:16];
        end
        if (sq >= 50'(lim_sq)) begin
          r.speed[i]   = lim;
          r.clipped[i] = 1'b1;
          clip_cnt++;
        end else begin
          r.speed[i] = floor_root(sq);
        end
      end
      return r;
    endfunction

    function void note_demand(demand_t d);
      pending_speeds.push_back(mix_rotor_speeds(d));
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    function void check_speeds(speeds_t got);
      speeds_t want;
      if (pending_speeds.size() == 0) begin
        flag("unexpected beat (rotor0 speed)", '0, 32'(got.speed[0]));
        return;
      end
      want = pending_speeds.pop_front();
      speeds_checked++;
      for (int i = 0; i < NUM_ROTORS; i++)
        if (got.speed[i] !== want.speed[i])
          flag($sformatf("rotor%0d speed, beat %0d", i, speeds_checked),
               32'(want.speed[i]), 32'(got.speed[i]));
      if (got.clipped !== want.clipped)
        flag($sformatf("clipped mask, beat %0d", speeds_checked),
             32'(want.clipped), 32'(got.clipped));
    endfunction

    function int pending();
      return pending_speeds.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // thrust, roll, pitch, yaw; 32 bits each from bit 0
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [OUT_W-1:0]     out_tdata;       // rotor0..rotor3 speeds (21 bits each), clipped_mask
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]    cfg_paddr = '0;
  logic [PDATA_W-1:0]   cfg_pwdata = '0;
  logic [PDATA_W-1:0]   cfg_prdata;
  logic                 cfg_pready;

  speed_tracker sb;
  int           in_idle_pct = 0;     // chance of a sender gap before a beat
  int           out_stall_pct = 0;   // chance of a receiver stall burst per cycle
  int           settings_cnt = 0;
  int           cycle_cnt = 0;

  quad_rotor_speed_mixer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: hold ready high, drop it in random bursts at the current rate.
  initial begin
    forever begin
      @(posedge clk);
      if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Check every result beat taken at this edge against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_speeds(speeds_t'(out_tdata));
  end

  // One APB transfer: setup phase, access phase, then an idle phase so that
  // back-to-back calls never assign psel twice in one step.
  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, {idx, 2'b00}, '0, rd);
    if (rd !== sb.reg_value(idx))
      sb.flag($sformatf("read of %s", idx.name()), sb.reg_value(idx), rd);
  endtask

  task automatic check_all_regs();
    for (int k = REG_ENABLE; k <= REG_MAX_SPEED; k++)
      check_reg(reg_idx_t'(k));
  endtask

  // Write a register, mirror it into the predictor and read it back.
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] v);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, {idx, 2'b00}, v, rd);
    sb.set_reg(idx, v);
    check_reg(idx);
  endtask

  // Load a full setting; random junk rides in the unused upper bits of the narrow registers.
  task automatic configure(input logic en, input logic [COEF_W-1:0] tc, input logic [COEF_W-1:0] ac,
                           input logic [COEF_W-1:0] yc, input logic [MAXSPD_W-1:0] ms);
    logic [PDATA_W-1:0] junk;
    junk = $urandom;
    write_reg(REG_ENABLE, {junk[31:1], en});
    write_reg(REG_THRUST_CF, tc);
    write_reg(REG_ARM_CF, ac);
    write_reg(REG_YAW_CF, yc);
    junk = $urandom;
    write_reg(REG_MAX_SPEED, {junk[31:MAXSPD_W], ms});
    settings_cnt++;
  endtask

  // Offer one beat, maybe after a sender gap, and return at the edge that takes it.
  task automatic send_demand(input demand_t d);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_demand(d);
  endtask

  // Drop valid and hold off until every predicted beat has come back.
  task automatic drain_stream();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic demand_t demand(input logic [31:0] t, input logic [31:0] r,
                                     input logic [31:0] p, input logic [31:0] y);
    demand_t d;
    d.thrust = t;
    d.roll   = r;
    d.pitch  = p;
    d.yaw    = y;
    return d;
  endfunction

  // Mostly scaled-down values so that rotors land on both sides of the limit,
  // with full-range words and extremes mixed in.
  function automatic logic [31:0] rand_field(input bit positive);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: return v;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: begin
        if (positive) return v >> $urandom_range(1, 31);
        return $signed(v) >>> $urandom_range(0, 31);
      end
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coeff();
    logic [COEF_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return v >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    logic [PDATA_W-1:0]  rd;
    logic [MAXSPD_W-1:0] ms;
    int                  base;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, and the disabled block must put out zeros.
    check_all_regs();
    send_demand(demand(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_demand(demand(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    drain_stream();

    // Coefficients of raw 2^24 (65536.0 in Q24.8) and a 100 rad/s limit: thrust alone then
    // gives a squared speed of thrust*256, so base lands exactly on the limit.
    configure(1'b1, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 13'd100);
    base = 100 * 100 * 256;
    send_demand(demand(base - 1, 0, 0, 0));
    send_demand(demand(base, 0, 0, 0));          // exactly the limit, not flagged
    send_demand(demand(base + 1, 0, 0, 0));
    send_demand(demand(base + 200, 0, 0, 0));    // just below (limit+1)^2
    send_demand(demand(base + 201, 0, 0, 0));    // first clipped value
    // Single torques: the rotors that subtract them go negative and clamp.
    send_demand(demand(0, 32'h0010_0000, 0, 0));
    send_demand(demand(0, 0, 32'h0010_0000, 0));
    send_demand(demand(0, 0, 0, 32'h0010_0000));
    send_demand(demand(32'hFFF0_0000, 0, 0, 0)); // negative thrust
    send_demand(demand(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_demand(demand(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_demand(demand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_demand(demand(0, 0, 0, 0));
    drain_stream();

    // Zero limit: any nonzero speed clips to zero; a zero speed does not flag.
    write_reg(REG_MAX_SPEED, '0);
    send_demand(demand(0, 0, 0, 0));
    send_demand(demand(1, 0, 0, 0));
    drain_stream();

    // A write past the register map must leave every register alone.
    apb_access(1'b1, SPARE_ADDR, '1, rd);
    check_all_regs();
    send_demand(demand(32'h0100_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000));
    drain_stream();

    // Largest coefficients and limit.
    configure(1'b1, '1, '1, '1, 13'd8191);
    send_demand(demand(32'h7FFF_FFFF, 0, 0, 0));
    send_demand(demand(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_demand(demand(32'h0000_0100, 32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_0008));
    drain_stream();

    // Disabled with live coefficients.
    write_reg(REG_ENABLE, '0);
    send_demand(demand(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
    drain_stream();

    // Random phases, each under its own setting; the last runs with no idling.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      ms = MAXSPD_W'($urandom_range(0, 8191));
      case (ph)
        0:       configure(1'b1, '1, '1, '1, 13'd8191);
        1:       configure(1'b1, rand_coeff(), rand_coeff(), rand_coeff(), '0);
        2:       configure(1'b1, '0, '0, '0, ms);
        3:       configure(1'b0, rand_coeff(), rand_coeff(), rand_coeff(), ms);
        default: configure(1'b1, rand_coeff(), rand_coeff(), rand_coeff(), ms);
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == NUM_PHASES - 1) begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end else if (n % 40 == 0) begin
          in_idle_pct   = pick_rate();
          out_stall_pct = pick_rate();
        end
        // Let the pipeline run dry once in the middle of a phase.
        if (ph == 4 && n == 60) drain_stream();
        send_demand(demand(rand_field(1'b1), rand_field(1'b0), rand_field(1'b0),
                           rand_field(1'b0)));
      end
      drain_stream();
    end

    // Watch for stray beats past the pipeline latency.
    repeat (PIPE_LATENCY + 15) @(posedge clk);
    $display("checked %0d result beats under %0d register settings",
             sb.speeds_checked, settings_cnt);
    $display("%0d rotors saturated, %0d rotor sums clamped at zero",
             sb.clip_cnt, sb.clamp_cnt);
    if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatch_cnt, sb.pending());
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/qrsm_pkg.sv
sv/qrsm_prod.sv
sv/qrsm_sqrt.sv
sv/qrsm_lane.sv
sv/quad_rotor_speed_mixer.sv
test/quad_rotor_speed_mixer_test.sv
